### sv/owb_pkg.sv
`default_nettype none

package owb_pkg;

	localparam int unsigned TickW = 9;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_RESET = 2'd1,
		OP_WRITE = 2'd2,
		OP_READ  = 2'd3
	} owb_op_t;

	localparam logic [TickW-1:0] T_RST_LOW  = 9'd480;
	localparam logic [TickW-1:0] T_RST_REL  = 9'd70;
	localparam logic [TickW-1:0] T_RST_WAIT = 9'd410;
	localparam logic [TickW-1:0] T_WR1_LOW  = 9'd6;
	localparam logic [TickW-1:0] T_WR1_REL  = 9'd58;
	localparam logic [TickW-1:0] T_WR0_LOW  = 9'd60;
	localparam logic [TickW-1:0] T_WR0_REL  = 9'd10;
	localparam logic [TickW-1:0] T_RD_LOW   = 9'd6;
	localparam logic [TickW-1:0] T_RD_SAMP  = 9'd9;
	localparam logic [TickW-1:0] T_RD_REC   = 9'd55;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] data_byte;
		logic       bus_level;
	} owb_in_t;

	typedef struct packed {
		logic       drive_low;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       presence;
		logic       rejected;
	} owb_out_t;

endpackage

`default_nettype wire

### sv/owb_seq.sv
`default_nettype none

module owb_seq (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               step,
	input  owb_pkg::owb_in_t  req,
	output owb_pkg::owb_out_t rslt
);
	import owb_pkg::*;

	typedef enum logic [3:0] {
		PH_IDLE     = 4'd0,
		PH_RST_LOW  = 4'd1,
		PH_RST_REL  = 4'd2,
		PH_RST_WAIT = 4'd3,
		PH_WR_LOW   = 4'd4,
		PH_WR_REL   = 4'd5,
		PH_RD_LOW   = 4'd6,
		PH_RD_SAMP  = 4'd7,
		PH_RD_REC   = 4'd8
	} phase_t;

	phase_t           phase_q, phase_d;
	logic [TickW-1:0] tick_q, tick_d, tick_inc, seg_len;
	logic [2:0]       bit_q, bit_d;
	logic [7:0]       shift_q, shift_d;
	logic [7:0]       rd_q, rd_d;
	logic             pres_q, pres_d;
	owb_op_t          kind_q, kind_d;
	logic             done, rej;

	always_comb begin
		case (phase_q)
			PH_RST_LOW:  seg_len = T_RST_LOW;
			PH_RST_REL:  seg_len = T_RST_REL;
			PH_RST_WAIT: seg_len = T_RST_WAIT;
			PH_WR_LOW:   seg_len = shift_q[0] ? T_WR1_LOW : T_WR0_LOW;
			PH_WR_REL:   seg_len = shift_q[0] ? T_WR1_REL : T_WR0_REL;
			PH_RD_LOW:   seg_len = T_RD_LOW;
			PH_RD_SAMP:  seg_len = T_RD_SAMP;
			PH_RD_REC:   seg_len = T_RD_REC;
			default:     seg_len = TickW'(1);
		endcase
	end

	assign tick_inc = tick_q + TickW'(1);

	always_comb begin
		phase_d = phase_q;
		tick_d  = tick_q;
		bit_d   = bit_q;
		shift_d = shift_q;
		rd_d    = rd_q;
		pres_d  = pres_q;
		kind_d  = kind_q;
		done    = 1'b0;
		rej     = 1'b0;
		if (owb_op_t'(req.opcode) != OP_TICK) begin
			if (phase_q != PH_IDLE) begin
				rej = 1'b1;
			end else begin
				kind_d = owb_op_t'(req.opcode);
				tick_d = '0;
				bit_d  = '0;
				case (owb_op_t'(req.opcode))
					OP_RESET: begin
						pres_d  = 1'b0;
						phase_d = PH_RST_LOW;
					end
					OP_WRITE: begin
						shift_d = req.data_byte;
						phase_d = PH_WR_LOW;
					end
					default: begin
						shift_d = '0;
						phase_d = PH_RD_LOW;
					end
				endcase
			end
		end else if (phase_q != PH_IDLE) begin
			tick_d = tick_inc;
			if (tick_inc >= seg_len) begin
				tick_d = '0;
				case (phase_q)
					PH_RST_LOW: phase_d = PH_RST_REL;
					PH_RST_REL: begin
						if (!req.bus_level) begin
							pres_d  = 1'b1;
							phase_d = PH_RST_WAIT;
						end else begin
							pres_d  = 1'b0;
							phase_d = PH_IDLE;
							done    = 1'b1;
						end
					end
					PH_WR_LOW: phase_d = PH_WR_REL;
					PH_WR_REL: begin
						shift_d = {1'b0, shift_q[7:1]};
						bit_d   = bit_q + 3'd1;
						if (bit_q == 3'd7) begin
							phase_d = PH_IDLE;
							done    = 1'b1;
						end else begin
							phase_d = PH_WR_LOW;
						end
					end
					PH_RD_LOW: phase_d = PH_RD_SAMP;
					PH_RD_SAMP: begin
						shift_d = {req.bus_level, shift_q[7:1]};
						phase_d = PH_RD_REC;
					end
					PH_RD_REC: begin
						bit_d = bit_q + 3'd1;
						if (bit_q == 3'd7) begin
							rd_d    = shift_q;
							phase_d = PH_IDLE;
							done    = 1'b1;
						end else begin
							phase_d = PH_RD_LOW;
						end
					end
					default: begin
						phase_d = PH_IDLE;
						done    = 1'b1;
					end
				endcase
			end
		end
	end

	always_comb begin
		rslt.drive_low = (phase_d == PH_RST_LOW) || (phase_d == PH_WR_LOW) ||
			(phase_d == PH_RD_LOW);
		rslt.busy_res  = (phase_d != PH_IDLE);
		rslt.done_res  = done;
		rslt.read_data = rd_d;
		rslt.presence  = pres_d;
		rslt.rejected  = rej;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q  <= '0;
			bit_q   <= '0;
			shift_q <= '0;
			rd_q    <= '0;
			pres_q  <= 1'b0;
			kind_q  <= OP_TICK;
		end else if (step) begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
			bit_q   <= bit_d;
			shift_q <= shift_d;
			rd_q    <= rd_d;
			pres_q  <= pres_d;
			kind_q  <= kind_d;
		end
	end

endmodule

`default_nettype wire

### sv/owb_out_reg.sv
`default_nettype none

module owb_out_reg (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               load,
	input  owb_pkg::owb_out_t rslt,
	output logic              out_valid,
	input  wire               out_ready,
	output owb_pkg::owb_out_t out_data,
	output logic              space
);
	import owb_pkg::*;

	logic valid_q;

	// room for a new request when no result is held or the held result leaves this cycle
	assign space     = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_data <= rslt;
		end
	end

endmodule

`default_nettype wire

### sv/one_wire_bus_master.sv
// channel  direction  handshake              payload
// in       to block   in_valid / in_ready    in_data  (owb_pkg::owb_in_t)
// out      from block out_valid / out_ready  out_data (owb_pkg::owb_out_t)
//
// One request a cycle while in_ready is high; its result is registered and offered the next cycle.
// The sequencer state updates on the accepting edge, so the only latency is
// the result register. in_ready is low only while a result is held and
// out_ready is low. arst_n clears the sequencer to idle and empties the
// result register.
`default_nettype none

module one_wire_bus_master (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  owb_pkg::owb_in_t  in_data,
	output logic              out_valid,
	input  wire               out_ready,
	output owb_pkg::owb_out_t out_data
);
	import owb_pkg::*;

	owb_out_t rslt;
	logic     space;
	logic     step;

	assign in_ready = space;
	assign step     = in_valid && space;

	owb_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.req    (in_data),
		.rslt   (rslt)
	);

	owb_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step),
		.rslt      (rslt),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.space     (space)
	);

endmodule

`default_nettype wire

### test/owb_bus_checker.sv
module owb_bus_checker (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	input  wire               in_ready,
	input  owb_pkg::owb_in_t  in_data,
	input  wire               out_valid,
	input  wire               out_ready,
	input  owb_pkg::owb_out_t out_data,
	output int                fails,
	output int                pending
);
	import owb_pkg::*;

	typedef enum logic [3:0] {
		SEQ_IDLE,
		SEQ_RST_LOW,
		SEQ_RST_REL,
		SEQ_RST_WAIT,
		SEQ_WR_LOW,
		SEQ_WR_REL,
		SEQ_RD_LOW,
		SEQ_RD_SAMP,
		SEQ_RD_REC
	} seq_t;

	seq_t           seq;
	logic [8:0]     ticks;
	logic [2:0]     bit_no;
	logic [7:0]     shreg;
	logic           presence_q;
	logic [7:0]     last_byte;
	int             results_seen;
	owb_out_t       expected_status[$];

	function automatic logic [8:0] segment_ticks(input seq_t s, input logic lsb);
		case (s)
		SEQ_RST_LOW:  return T_RST_LOW;
		SEQ_RST_REL:  return T_RST_REL;
		SEQ_RST_WAIT: return T_RST_WAIT;
		SEQ_WR_LOW:   return lsb ? T_WR1_LOW : T_WR0_LOW;
		SEQ_WR_REL:   return lsb ? T_WR1_REL : T_WR0_REL;
		SEQ_RD_LOW:   return T_RD_LOW;
		SEQ_RD_SAMP:  return T_RD_SAMP;
		SEQ_RD_REC:   return T_RD_REC;
		default:      return 9'd1;
		endcase
	endfunction

	task automatic advance_sequencer(input owb_in_t req, output owb_out_t res);
		logic fin;
		logic rej;
		fin = 1'b0;
		rej = 1'b0;
		if (req.opcode != OP_TICK) begin
			if (seq != SEQ_IDLE) begin
				rej = 1'b1;
			end else begin
				ticks = '0;
				bit_no = '0;
				case (req.opcode)
				OP_RESET: begin
					presence_q = 1'b0;
					seq = SEQ_RST_LOW;
				end
				OP_WRITE: begin
					shreg = req.data_byte;
					seq = SEQ_WR_LOW;
				end
				default: begin
					shreg = '0;
					seq = SEQ_RD_LOW;
				end
				endcase
			end
		end else if (seq != SEQ_IDLE) begin
			ticks = ticks + 9'd1;
			if (ticks >= segment_ticks(seq, shreg[0])) begin
				ticks = '0;
				case (seq)
				SEQ_RST_LOW: seq = SEQ_RST_REL;
				SEQ_RST_REL: begin
					// line held low by a device at the sample point
					presence_q = !req.bus_level;
					if (!req.bus_level) begin
						seq = SEQ_RST_WAIT;
					end else begin
						seq = SEQ_IDLE;
						fin = 1'b1;
					end
				end
				SEQ_WR_LOW: seq = SEQ_WR_REL;
				SEQ_WR_REL: begin
					shreg = shreg >> 1;
					if (bit_no == 3'd7) begin
						bit_no = '0;
						seq = SEQ_IDLE;
						fin = 1'b1;
					end else begin
						bit_no = bit_no + 3'd1;
						seq = SEQ_WR_LOW;
					end
				end
				SEQ_RD_LOW: seq = SEQ_RD_SAMP;
				SEQ_RD_SAMP: begin
					shreg = {req.bus_level, shreg[7:1]};
					seq = SEQ_RD_REC;
				end
				SEQ_RD_REC: begin
					if (bit_no == 3'd7) begin
						bit_no = '0;
						last_byte = shreg;
						seq = SEQ_IDLE;
						fin = 1'b1;
					end else begin
						bit_no = bit_no + 3'd1;
						seq = SEQ_RD_LOW;
					end
				end
				default: begin
					seq = SEQ_IDLE;
					fin = 1'b1;
				end
				endcase
			end
		end
		res.drive_low = (seq == SEQ_RST_LOW) || (seq == SEQ_WR_LOW) || (seq == SEQ_RD_LOW);
		res.busy_res  = (seq != SEQ_IDLE);
		res.done_res  = fin;
		res.read_data = last_byte;
		res.presence  = presence_q;
		res.rejected  = rej;
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		if (fails < 40)
			$display("mismatch on result %0d, %s: got %0d, expected %0d",
				results_seen, what, got, want);
		fails++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		owb_out_t want;
		if (!arst_n) begin
			seq = SEQ_IDLE;
			ticks = '0;
			bit_no = '0;
			shreg = '0;
			presence_q = 1'b0;
			last_byte = '0;
			results_seen = 0;
			fails = 0;
			expected_status.delete();
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_status.size() == 0) begin
					report_mismatch("result with no request outstanding", 1, 0);
				end else begin
					want = expected_status.pop_front();
					if (out_data.drive_low !== want.drive_low)
						report_mismatch("drive_low", out_data.drive_low, want.drive_low);
					if (out_data.busy_res !== want.busy_res)
						report_mismatch("busy_res", out_data.busy_res, want.busy_res);
					if (out_data.done_res !== want.done_res)
						report_mismatch("done_res", out_data.done_res, want.done_res);
					if (out_data.read_data !== want.read_data)
						report_mismatch("read_data", out_data.read_data, want.read_data);
					if (out_data.presence !== want.presence)
						report_mismatch("presence", out_data.presence, want.presence);
					if (out_data.rejected !== want.rejected)
						report_mismatch("rejected", out_data.rejected, want.rejected);
				end
				results_seen++;
			end
			if (in_valid && in_ready) begin
				advance_sequencer(in_data, want);
				expected_status.push_back(want);
			end
			pending = expected_status.size();
		end
	end

endmodule

### test/tb_top.sv
module tb_top;
	import owb_pkg::*;

	localparam int NO_IDLE    = 0;
	localparam int SEND_IDLE  = 1;
	localparam int RECV_STALL = 2;
	localparam int BOTH_IDLE  = 3;

	localparam int LVL_LOW  = 0;
	localparam int LVL_HIGH = 1;
	localparam int LVL_RAND = 2;

	localparam int HOLD_CYCLES = 300;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     in_valid = 1'b0;
	logic     in_ready;
	owb_in_t  in_data = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	owb_out_t out_data;

	int fails;
	int pending;
	int idle_mode = NO_IDLE;
	int hold_asked = 0;
	int hold_taken = 0;
	int hold_left = 0;

	always #4 clk = ~clk;

	one_wire_bus_master uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	owb_bus_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.fails     (fails),
		.pending   (pending)
	);

	always @(posedge clk) begin : receiver
		int pct;
		pct = (idle_mode == RECV_STALL) ? 81 : (idle_mode == BOTH_IDLE) ? 14 : 0;
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_taken != hold_asked) begin
			out_ready <= 1'b0;
			hold_taken <= hold_taken + 1;
			hold_left <= HOLD_CYCLES;
		end else begin
			out_ready <= !($urandom_range(99) < pct);
		end
	end

	initial begin
		#200_000;
		$display("FAIL");
		$finish;
	end

	task automatic send_req(input owb_in_t req);
		int pct;
		pct = (idle_mode == SEND_IDLE) ? 81 : (idle_mode == BOTH_IDLE) ? 14 : 0;
		while ($urandom_range(99) < pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic idle_ticks(input int n);
		owb_in_t req;
		repeat (n) begin
			req.opcode = OP_TICK;
			req.data_byte = 8'($urandom);
			req.bus_level = 1'($urandom_range(1));
			send_req(req);
		end
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		@(posedge clk);
	endtask

	// a command followed by the ticks it needs, cut short after cap ticks;
	// commands slipped in while busy must be refused
	task automatic run_command(input owb_op_t op, input logic [7:0] data,
			input int lvl_mode, input int rej_pct, input int cap);
		owb_in_t req;
		int total;
		int k;
		req.opcode = op;
		req.data_byte = data;
		req.bus_level = 1'($urandom_range(1));
		send_req(req);
		case (op)
		OP_RESET: total = int'(T_RST_LOW) + int'(T_RST_REL);
		OP_WRITE: begin
			total = 0;
			for (int i = 0; i < 8; i++)
				total += data[i] ? int'(T_WR1_LOW) + int'(T_WR1_REL)
					: int'(T_WR0_LOW) + int'(T_WR0_REL);
		end
		default: total = 8 * (int'(T_RD_LOW) + int'(T_RD_SAMP) + int'(T_RD_REC));
		endcase
		k = 0;
		while (k < total && k < cap) begin
			if ($urandom_range(99) < rej_pct) begin
				req.opcode = owb_op_t'(2'($urandom_range(3, 1)));
				req.data_byte = 8'($urandom);
				req.bus_level = 1'($urandom_range(1));
				send_req(req);
			end
			req.opcode = OP_TICK;
			req.data_byte = 8'($urandom);
			case (lvl_mode)
			LVL_LOW:  req.bus_level = 1'b0;
			LVL_HIGH: req.bus_level = 1'b1;
			default:  req.bus_level = 1'($urandom_range(1));
			endcase
			send_req(req);
			k++;
			if (op == OP_RESET && k == int'(T_RST_LOW) + int'(T_RST_REL) && !req.bus_level)
				total += int'(T_RST_WAIT);
		end
	endtask

	initial begin
		owb_op_t op;
		int lv;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_mode = NO_IDLE;
		idle_ticks(2);
		run_command(OP_RESET, 8'($urandom), LVL_HIGH, 4, 600);
		drain;

		// long receiver hold while requests keep coming
		hold_asked <= hold_asked + 1;
		run_command(OP_WRITE, 8'h5A, LVL_RAND, 2, 140);
		drain;

		for (int m = NO_IDLE; m <= BOTH_IDLE; m++) begin
			idle_mode = m;
			repeat (2) begin
				op = owb_op_t'(2'($urandom_range(3, 1)));
				case ($urandom_range(9))
				0:       lv = LVL_LOW;
				1:       lv = LVL_HIGH;
				default: lv = LVL_RAND;
				endcase
				run_command(op, 8'($urandom), lv, 3, 12);
				idle_ticks(int'($urandom_range(3)));
			end
			drain;
		end

		idle_mode = NO_IDLE;
		drain;
		repeat (8) @(posedge clk);
		if (fails == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
